### design/stg_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and the sine table function of the sine tone generator.
package stg_pkg;

  localparam int SampleW = 16;
  localparam int FreqW   = 16;
  localparam int LenW    = 16;
  localparam int AmpW    = 15;
  localparam int MagW    = 15;
  localparam int PhaseW  = 32;
  localparam int ToneW   = 21;
  localparam int TailW   = 9;

  localparam logic [ToneW-1:0] ToneMax  = '1;
  localparam logic [MagW-1:0]  Peak     = 15'h7FFF;
  localparam logic [AmpW-1:0]  AmpReset = 15'd3000;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] Q30One    = 64'd1 << 30;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                op;
    logic                   freq_zero;
    logic [ToneW-1:0]       count;
    logic [PhaseW-1:0]      step;
  } stg_cmd_t;

  typedef struct packed {
    logic [MagW-1:0] mag;
    logic            neg;
    logic            last;
  } stg_smp_t;

  function automatic logic [MagW-1:0] sine_q15(input int unsigned i, input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = (HalfPiQ30 * 64'(i)) >> tbits;
    x2 = (x * x) >> 30;
    t  = Q30One;
    t  = Q30One - (((x2 * t) >> 30) / 64'd156);
    t  = Q30One - (((x2 * t) >> 30) / 64'd110);
    t  = Q30One - (((x2 * t) >> 30) / 64'd72);
    t  = Q30One - (((x2 * t) >> 30) / 64'd42);
    t  = Q30One - (((x2 * t) >> 30) / 64'd20);
    t  = Q30One - (((x2 * t) >> 30) / 64'd6);
    t  = (x * t) >> 30;
    t  = (64'd32767 * t + (Q30One >> 1)) >> 30;
    if (t > 64'd32767) begin
      t = 64'd32767;
    end
    return MagW'(t);
  endfunction

endpackage

### design/stg_front.sv
`timescale 1ns / 1ps
// Input register: sample count and phase step products of a start word.
module stg_front import stg_pkg::*; #(
  parameter int AUDIO_RATE = 16000
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_opcode,
  input  logic [FreqW-1:0] in_tone_freq_hz,
  input  logic [LenW-1:0]  in_tone_length_ms,
  output stg_cmd_t         cmd_o,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i
);

  localparam int CntShift  = 26;
  localparam int CntMulW   = 32;
  localparam int CntProdW  = LenW + CntMulW;
  localparam int CntW      = CntProdW - CntShift;
  localparam int StepShift = 32;
  localparam int StepMulW  = 52;
  localparam int StepProdW = FreqW + StepMulW;

  localparam logic [63:0] CntScaled = (64'(AUDIO_RATE) << CntShift) + 64'd999;
  localparam logic [CntMulW-1:0] CntMul = CntMulW'(CntScaled / 64'd1000);
  localparam logic [63:0] AllOnes = '1;
  localparam logic [StepMulW-1:0] StepMul = StepMulW'(AllOnes / 64'(AUDIO_RATE) + 64'd1);

  logic [CntProdW-1:0]  cnt_prod;
  logic [CntW-1:0]      cnt_raw;
  logic [ToneW-1:0]     cnt_sat;
  logic [StepProdW-1:0] step_prod;
  stg_cmd_t             cmd_r;
  logic                 valid_r;

  assign cnt_prod  = CntProdW'(in_tone_length_ms) * CntProdW'(CntMul);
  assign cnt_raw   = cnt_prod[CntProdW-1:CntShift];
  assign cnt_sat   = (cnt_raw > CntW'(ToneMax)) ? ToneMax : cnt_raw[ToneW-1:0];
  assign step_prod = StepProdW'(in_tone_freq_hz) * StepProdW'(StepMul);

  assign in_ready    = !valid_r || cmd_ready_i;
  assign cmd_o       = cmd_r;
  assign cmd_valid_o = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r.op        <= opcode_t'(in_opcode);
      cmd_r.freq_zero <= (in_tone_freq_hz == '0);
      cmd_r.count     <= cnt_sat;
      cmd_r.step      <= step_prod[StepShift+PhaseW-1:StepShift];
    end
  end

endmodule

### design/stg_core.sv
`timescale 1ns / 1ps
// Tone state, phase accumulator and quarter-wave sine table read.
module stg_core import stg_pkg::*; #(
  parameter int TAIL_SAMPLES = 320,
  parameter int TABLE_BITS   = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  stg_cmd_t cmd_i,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  output stg_smp_t smp_o,
  output logic     smp_valid_o,
  input  logic     smp_ready_i
);

  localparam int TableSize = 1 << TABLE_BITS;
  localparam logic [TailW-1:0] TailInit = TailW'(TAIL_SAMPLES);

  typedef logic [MagW-1:0] rom_t [TableSize];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < TableSize; i++) begin
      r[i] = sine_q15(32'(i), 32'(TABLE_BITS));
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [PhaseW-1:0]     phase_acc_r, phase_acc_nxt;
  logic [PhaseW-1:0]     phase_step_r, phase_step_nxt;
  logic [ToneW-1:0]      tone_left_r, tone_left_nxt;
  logic [TailW-1:0]      tail_left_r, tail_left_nxt;
  logic                  is_rest_r, is_rest_nxt;
  logic                  smp_valid_r;
  stg_smp_t              smp_r;

  logic                  fire;
  logic                  emit;
  logic                  silent;
  logic                  last;
  logic [1:0]            quad;
  logic [TABLE_BITS-1:0] idx;
  logic [TABLE_BITS-1:0] rom_addr;
  logic                  peak;

  assign cmd_ready_o = !smp_valid_r || smp_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign smp_o       = smp_r;
  assign smp_valid_o = smp_valid_r;

  assign quad     = phase_acc_r[PhaseW-1 -: 2];
  assign idx      = phase_acc_r[PhaseW-3 -: TABLE_BITS];
  assign rom_addr = quad[0] ? TABLE_BITS'(~idx + 1'b1) : idx;
  assign peak     = quad[0] && (idx == '0);

  always_comb begin
    phase_acc_nxt  = phase_acc_r;
    phase_step_nxt = phase_step_r;
    tone_left_nxt  = tone_left_r;
    tail_left_nxt  = tail_left_r;
    is_rest_nxt    = is_rest_r;
    emit           = 1'b0;
    silent         = 1'b1;
    last           = 1'b0;
    if (fire) begin
      unique case (cmd_i.op)
        OP_START: begin
          phase_acc_nxt  = '0;
          phase_step_nxt = cmd_i.step;
          tone_left_nxt  = cmd_i.count;
          is_rest_nxt    = cmd_i.freq_zero;
          tail_left_nxt  = cmd_i.freq_zero ? '0 : TailInit;
        end
        OP_TICK: begin
          if (tone_left_r != '0) begin
            emit          = 1'b1;
            silent        = is_rest_r;
            if (!is_rest_r) begin
              phase_acc_nxt = phase_acc_r + phase_step_r;
            end
            tone_left_nxt = tone_left_r - 1'b1;
            last          = (tone_left_nxt == '0) && (tail_left_r == '0);
          end else if (tail_left_r != '0) begin
            emit          = 1'b1;
            tail_left_nxt = tail_left_r - 1'b1;
            last          = (tail_left_nxt == '0);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r  <= '0;
      phase_step_r <= '0;
      tone_left_r  <= '0;
      tail_left_r  <= '0;
      is_rest_r    <= 1'b0;
      smp_valid_r  <= 1'b0;
    end else begin
      phase_acc_r  <= phase_acc_nxt;
      phase_step_r <= phase_step_nxt;
      tone_left_r  <= tone_left_nxt;
      tail_left_r  <= tail_left_nxt;
      is_rest_r    <= is_rest_nxt;
      if (cmd_ready_o) begin
        smp_valid_r <= fire && emit;
      end
    end
  end

  // hold the table read and sign of the current phase for the scaling stage
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      smp_r.mag  <= silent ? '0 : (peak ? Peak : SineRom[rom_addr]);
      smp_r.neg  <= !silent && quad[1];
      smp_r.last <= last;
    end
  end

endmodule

### design/stg_scale.sv
`timescale 1ns / 1ps
// Amplitude scaling, sign and output register of the sample word.
module stg_scale import stg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [AmpW-1:0]           amplitude_i,
  input  stg_smp_t                  smp_i,
  input  logic                      smp_valid_i,
  output logic                      smp_ready_o,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SampleW-1:0] out_sample,
  output logic                      out_last_sample
);

  localparam int ProdW = AmpW + MagW;

  logic [ProdW-1:0]          prod;
  logic [SampleW-1:0]        mag_ext;
  logic [SampleW-1:0]        sample_nxt;
  logic                      out_valid_r;
  logic signed [SampleW-1:0] sample_r;
  logic                      last_r;

  assign prod       = ProdW'(amplitude_i) * ProdW'(smp_i.mag);
  assign mag_ext    = SampleW'(prod[ProdW-1:MagW]);
  assign sample_nxt = smp_i.neg ? (~mag_ext + 1'b1) : mag_ext;

  assign smp_ready_o     = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_sample      = sample_r;
  assign out_last_sample = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (smp_ready_o) begin
      out_valid_r <= smp_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_valid_i && smp_ready_o) begin
      sample_r <= $signed(sample_nxt);
      last_r   <= smp_i.last;
    end
  end

endmodule

### design/sine_tone_generator.sv
`timescale 1ns / 1ps
// Top level of the sine tone generator: amplitude register and pipeline stages.
//
//   channel  handshake            payload                                         role
//   in       in_valid/in_ready    in_opcode, in_tone_freq_hz, in_tone_length_ms   input words
//   out      out_valid/out_ready  out_sample, out_last_sample                     result words
//   cfg      cfg_valid/cfg_ready  cfg_wdata                                       amplitude write
//
// One word is taken per cycle while in_ready is high; a tick's sample passes
// through the input register, the state stage and the output register before it is shown.
// The state stage updates phase and counters for one word per cycle unless the output stalls.
// Reset is synchronous: counters and phase clear, amplitude loads 3000.
// A stall at the output fills the three stages in turn and then drops in_ready.
module sine_tone_generator import stg_pkg::*; #(
  parameter int AUDIO_RATE   = 16000,
  parameter int TAIL_SAMPLES = 320,
  parameter int TABLE_BITS   = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_opcode,
  input  logic [FreqW-1:0]          in_tone_freq_hz,
  input  logic [LenW-1:0]           in_tone_length_ms,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SampleW-1:0] out_sample,
  output logic                      out_last_sample,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [AmpW-1:0]           cfg_wdata
);

  logic [AmpW-1:0] amplitude_r;
  stg_cmd_t        cmd;
  logic            cmd_valid;
  logic            cmd_ready;
  stg_smp_t        smp;
  logic            smp_valid;
  logic            smp_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r <= AmpReset;
    end else if (cfg_valid && cfg_ready) begin
      amplitude_r <= cfg_wdata;
    end
  end

  stg_front #(
    .AUDIO_RATE(AUDIO_RATE)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_tone_freq_hz  (in_tone_freq_hz),
    .in_tone_length_ms(in_tone_length_ms),
    .cmd_o            (cmd),
    .cmd_valid_o      (cmd_valid),
    .cmd_ready_i      (cmd_ready)
  );

  stg_core #(
    .TAIL_SAMPLES(TAIL_SAMPLES),
    .TABLE_BITS  (TABLE_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .smp_o      (smp),
    .smp_valid_o(smp_valid),
    .smp_ready_i(smp_ready)
  );

  stg_scale u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .amplitude_i    (amplitude_r),
    .smp_i          (smp),
    .smp_valid_i    (smp_valid),
    .smp_ready_o    (smp_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample     (out_sample),
    .out_last_sample(out_last_sample)
  );

endmodule

### bench/sine_tone_generator_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the sine tone generator: directed table, random phases, predictor.
module sine_tone_generator_test;
  import stg_pkg::*;

  localparam int RATE   = 16000;
  localparam int TAIL   = 320;
  localparam int TBITS  = 8;
  localparam int TSIZE  = 1 << TBITS;
  localparam int ITEMS  = 1400;
  localparam int SETTLE = 8;
  localparam int LIMIT  = 400000;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [SampleW-1:0] smp;
    logic                      last;
  } tone_word_t;

  typedef struct packed {
    opcode_t          op;
    logic [FreqW-1:0] freq;
    logic [LenW-1:0]  len;
    logic             typed;
    logic             has;
    tone_word_t       word;
  } stim_row_t;

  localparam int NDIR = 25;
  localparam stim_row_t DIRECTED [0:NDIR-1] = '{
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 1'b0, '{16'sd0, 1'b0}},
    '{OP_START, 16'd4000,  16'd1,     1'b1, 1'b0, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 1'b1, '{16'sd2999, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 1'b1, '{-16'sd2999, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{OP_START, 16'd0,     16'd0,     1'b1, 1'b0, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'hFFFF,  16'hFFFF,  1'b1, 1'b0, '{16'sd0, 1'b0}},
    '{OP_START, 16'd0,     16'd1,     1'b1, 1'b0, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{OP_START, 16'hFFFF,  16'hFFFF,  1'b1, 1'b0, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{OP_START, 16'd16000, 16'd0,     1'b1, 1'b0, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{OP_START, 16'd1,     16'd1,     1'b1, 1'b0, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{OP_START, 16'd8000,  16'd2,     1'b1, 1'b0, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 1'b0, '{16'sd0, 1'b0}}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_opcode;
  logic [FreqW-1:0]          in_tone_freq_hz;
  logic [LenW-1:0]           in_tone_length_ms;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [SampleW-1:0] out_sample;
  logic                      out_last_sample;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [AmpW-1:0]           cfg_wdata;

  logic [AmpW-1:0]   amp_reg;
  logic [PhaseW-1:0] phase;
  logic [PhaseW-1:0] step;
  logic [ToneW-1:0]  tone_cnt;
  logic [TailW-1:0]  tail_cnt;
  logic              resting;
  logic [MagW-1:0]   quarter_wave [TSIZE];

  tone_word_t pending_words [$];
  int errors;
  int cycles;
  int words_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  sine_tone_generator #(
    .AUDIO_RATE(RATE),
    .TAIL_SAMPLES(TAIL),
    .TABLE_BITS(TBITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_tone_freq_hz(in_tone_freq_hz),
    .in_tone_length_ms(in_tone_length_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample(out_sample),
    .out_last_sample(out_last_sample),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_wdata(cfg_wdata)
  );

  function automatic logic [MagW-1:0] quarter_sine(input int unsigned i);
    longint unsigned divs [6];
    longint unsigned x;
    longint unsigned x2;
    longint unsigned acc;
    divs = '{156, 110, 72, 42, 20, 6};
    x = (HALF_PI_Q30 * 64'(i)) >> TBITS;
    x2 = (x * x) >> 30;
    acc = ONE_Q30;
    for (int k = 0; k < 6; k++) begin
      acc = ONE_Q30 - ((x2 * acc) >> 30) / divs[k];
    end
    acc = (x * acc) >> 30;
    acc = (64'd32767 * acc + (ONE_Q30 >> 1)) >> 30;
    return (acc > 64'd32767) ? 15'h7FFF : acc[MagW-1:0];
  endfunction

  function automatic bit advance_tone(input opcode_t op, input logic [FreqW-1:0] freq,
                                      input logic [LenW-1:0] len, output tone_word_t w);
    longint unsigned span;
    logic [1:0]       quad;
    logic [TBITS-1:0] idx;
    logic [MagW-1:0]  mag;
    logic [29:0]      prod;
    logic [15:0]      scaled;
    w = '0;
    if (op == OP_START) begin
      span = 64'(len) * RATE / 1000;
      phase = '0;
      step = PhaseW'((64'(freq) << 32) / RATE);
      tone_cnt = (span > 64'(ToneMax)) ? ToneMax : ToneW'(span);
      resting = (freq == '0);
      tail_cnt = resting ? '0 : TailW'(TAIL);
      return 1'b0;
    end
    if (tone_cnt != '0) begin
      if (!resting) begin
        quad = phase[31:30];
        idx = phase[29 -: TBITS];
        if (quad[0]) begin
          mag = (idx == '0) ? Peak : quarter_wave[TSIZE - int'(idx)];
        end else begin
          mag = quarter_wave[idx];
        end
        prod = 30'(amp_reg) * 30'(mag);
        scaled = 16'(prod >> 15);
        w.smp = quad[1] ? -scaled : scaled;
        phase = phase + step;
      end
      tone_cnt = tone_cnt - 1'b1;
      w.last = (tone_cnt == '0) && (tail_cnt == '0);
      return 1'b1;
    end
    if (tail_cnt != '0) begin
      tail_cnt = tail_cnt - 1'b1;
      w.last = (tail_cnt == '0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_word(input opcode_t op, input logic [FreqW-1:0] freq,
                           input logic [LenW-1:0] len, input bit typed, input bit typed_has,
                           input tone_word_t typed_word);
    tone_word_t w;
    bit         has;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_tone_freq_hz   <= freq;
    in_tone_length_ms <= len;
    do @(posedge clk); while (!in_ready);
    has = advance_tone(op, freq, len, w);
    if (typed) begin
      if (typed_has) pending_words.push_back(typed_word);
    end else if (has) begin
      pending_words.push_back(w);
    end
    if (has || op == OP_START) words_sent++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_amplitude(input logic [AmpW-1:0] value);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    amp_reg = value;
  endtask

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_words
    tone_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: sample %0d last %0b", $time, out_sample,
                 out_last_sample);
      end else begin
        want = pending_words.pop_front();
        if (out_sample !== want.smp) begin
          errors++;
          $display("%0t: sample expected %0d got %0d", $time, want.smp, out_sample);
        end
        if (out_last_sample !== want.last) begin
          errors++;
          $display("%0t: last_sample expected %0b got %0b", $time, want.last,
                   out_last_sample);
        end
      end
    end
  end

  initial begin : drive
    logic [AmpW-1:0]  amps [5];
    int               idle_mix [5];
    int               stall_mix [5];
    int               goal;
    int               pick;
    int               total;
    int               ticks;
    logic [FreqW-1:0] freq;
    logic [LenW-1:0]  len;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_opcode         = OP_START;
    in_tone_freq_hz   = '0;
    in_tone_length_ms = '0;
    out_ready         = 1'b0;
    cfg_valid         = 1'b0;
    cfg_wdata         = '0;
    errors            = 0;
    cycles            = 0;
    words_sent        = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_cycles       = 0;
    amp_reg           = AmpReset;
    phase             = '0;
    step              = '0;
    tone_cnt          = '0;
    tail_cnt          = '0;
    resting           = 1'b0;
    for (int i = 0; i < TSIZE; i++) quarter_wave[i] = quarter_sine(i);
    amps      = '{15'h7FFF, 15'd0, AmpW'($urandom_range(1, 32766)),
                  AmpW'($urandom_range(0, 32767)), 15'd1};
    idle_mix  = '{0, 62, 0, 38, 0};
    stall_mix = '{0, 0, 62, 38, 0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NDIR; r++) begin
      send_word(DIRECTED[r].op, DIRECTED[r].freq, DIRECTED[r].len, DIRECTED[r].typed,
                DIRECTED[r].has, DIRECTED[r].word);
    end

    for (int p = 0; p < 5; p++) begin
      write_amplitude(amps[p]);
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      if (p == 4) hold_cycles = 200;
      goal = words_sent + ITEMS / 5;
      while (words_sent < goal) begin
        if ($urandom_range(99) < 10) begin
          repeat ($urandom_range(1, 4)) begin
            send_word(opcode_t'($urandom_range(1)), FreqW'($urandom), LenW'($urandom),
                      1'b0, 1'b0, '0);
          end
        end else begin
          pick = $urandom_range(99);
          freq = (pick < 15) ? '0 : (pick < 30) ? FreqW'($urandom)
                                                : FreqW'($urandom_range(20, 8000));
          pick = $urandom_range(99);
          len  = (pick < 70) ? LenW'($urandom_range(0, 3)) :
                 (pick < 92) ? LenW'($urandom_range(4, 10)) : LenW'($urandom);
          total = int'(len) * 16 + ((freq != '0) ? TAIL : 0);
          if (total > 600 || $urandom_range(99) < 55) begin
            ticks = $urandom_range(1, 60);
          end else begin
            ticks = total + $urandom_range(0, 3);
          end
          send_word(OP_START, freq, len, 1'b0, 1'b0, '0);
          repeat (ticks) begin
            send_word(OP_TICK, FreqW'($urandom), LenW'($urandom), 1'b0, 1'b0, '0);
          end
        end
      end
    end

    quiesce();
    if (errors == 0 && pending_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
design/stg_pkg.sv
design/stg_front.sv
design/stg_core.sv
design/stg_scale.sv
design/sine_tone_generator.sv
bench/sine_tone_generator_test.sv
